// ----- rtl/hlrng_pkg.sv -----
// Shared types and constants for the seeded Lehmer generator.
package hlrng_pkg;

  localparam int HashBytes = 28;
  localparam int ByteCntW = $clog2(HashBytes);
  localparam int WarmupStepsDef = 5;

  localparam logic [14:0] LehmerMult = 15'd16807;
  localparam logic [30:0] LehmerMod = 31'h7fffffff;
  localparam logic [31:0] ReseedMask = 32'h07ffffff;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_FINAL,
    ST_SEED,
    ST_STEP,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mix;
    logic fin;
  } hash_ctrl_t;

endpackage

// ----- rtl/hlrng_hash.sv -----
// One-at-a-time hash unit: mixes one byte per cycle, then finalizes.
module hlrng_hash
  import hlrng_pkg::*;
(
  input  logic              clk,
  input  hash_ctrl_t        ctrl,
  input  logic signed [31:0] base_index,
  input  logic [63:0]       coord_x,
  input  logic [63:0]       coord_y,
  input  logic [63:0]       coord_z,
  output logic [31:0]       hash
);

  logic [HashBytes*8-1:0] bytes;
  logic [31:0]            h;
  logic [31:0]            mix_a;
  logic [31:0]            mix_b;
  logic [31:0]            mix_h;
  logic [31:0]            fin_a;
  logic [31:0]            fin_b;
  logic [31:0]            fin_h;

  // Bytes are sign-extended before they enter the accumulator.
  always_comb begin
    mix_a = h + {{24{bytes[7]}}, bytes[7:0]};
    mix_b = mix_a + (mix_a << 10);
    mix_h = mix_b ^ (mix_b >> 6);
    fin_a = h + (h << 3);
    fin_b = fin_a ^ (fin_a >> 11);
    fin_h = fin_b + (fin_b << 15);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bytes <= {coord_z, coord_y, coord_x, base_index};
      h     <= '0;
    end else if (ctrl.mix) begin
      bytes <= bytes >> 8;
      h     <= mix_h;
    end else if (ctrl.fin) begin
      h <= fin_h;
    end
  end

  assign hash = h;

endmodule

// ----- rtl/hlrng_lehmer.sv -----
// Two-stage generator step: multiply by 16807, then fold modulo 2^31-1.
module hlrng_lehmer
  import hlrng_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [30:0] operand,
  output logic        done,
  output logic [30:0] result
);

  logic [45:0] prod;
  logic        prod_vld;
  logic [31:0] fold;
  logic [31:0] fold_sub;

  // The modulus is a Mersenne number, so the high part folds onto the low part
  // and at most one subtraction remains.
  always_comb begin
    fold     = {1'b0, prod[30:0]} + {17'b0, prod[45:31]};
    fold_sub = fold - {1'b0, LehmerMod};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      prod_vld <= go;
      done     <= prod_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      prod <= 46'(operand) * 46'(LehmerMult);
    end
    if (prod_vld) begin
      result <= (fold >= {1'b0, LehmerMod}) ? fold_sub[30:0] : fold[30:0];
    end
  end

endmodule

// ----- rtl/hash_seeded_lehmer_rng.sv -----
// Top level of the seeded Lehmer generator: sequencer, state and output word.
//
// Each input word is either a draw or a reseed, and each gives exactly one
// output word holding the new 31-bit state and that state as a Q0.32 fraction
// of 2^31-1. A draw makes one pass through the shared two-stage multiply/fold
// unit and then loads the output register. A reseed runs the hash unit over
// its 28 bytes, finalizes, picks the masked seed, makes WARMUP_STEPS dependent
// passes through the same multiply/fold unit (the default is 5) and then loads
// the output. Words are only accepted in the idle state. The input stalls
// until the result has moved into the output register; the output register
// may still be waiting on the consumer while the next word is accepted.
module hash_seeded_lehmer_rng
  import hlrng_pkg::*;
#(
  parameter int WARMUP_STEPS = WarmupStepsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic signed [31:0] base_index,
  input  logic [63:0]        coord_x,
  input  logic [63:0]        coord_y,
  input  logic [63:0]        coord_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [30:0]        seed_out,
  output logic [31:0]        fraction
);

  localparam int StepW = $clog2(WARMUP_STEPS + 2);

  state_t               state;
  state_t               state_next;
  hash_ctrl_t           hctrl;
  logic                 step_go;
  logic                 step_done;
  logic [30:0]          step_result;
  logic [31:0]          hash;
  logic [31:0]          masked;
  logic [30:0]          seed;
  logic [30:0]          work;
  logic [StepW-1:0]     steps;
  logic [ByteCntW-1:0]  bcnt;
  logic                 accept;
  logic                 out_free;
  logic [31:0]          dbl;
  logic                 dbl_ge;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign masked   = hash & ReseedMask;

  // 2^32 / (2^31-1) is 2 plus 2/(2^31-1), so the fraction is 2s plus one
  // when 2s reaches the modulus.
  assign dbl    = {work, 1'b0};
  assign dbl_ge = dbl >= {1'b0, LehmerMod};

  hlrng_hash u_hash (
    .clk        (clk),
    .ctrl       (hctrl),
    .base_index (base_index),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .hash       (hash)
  );

  hlrng_lehmer u_lehmer (
    .clk     (clk),
    .rst     (rst),
    .go      (step_go),
    .operand (work),
    .done    (step_done),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    hctrl      = '0;
    step_go    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (opcode) begin
            state_next = ST_STEP;
          end else begin
            hctrl.load = 1'b1;
            state_next = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        hctrl.mix = 1'b1;
        if (bcnt == ByteCntW'(HashBytes - 1)) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        hctrl.fin  = 1'b1;
        state_next = ST_SEED;
      end
      ST_SEED: begin
        state_next = (steps == '0) ? ST_DONE : ST_STEP;
      end
      ST_STEP: begin
        step_go    = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (step_done) begin
          state_next = (steps == StepW'(1)) ? ST_DONE : ST_STEP;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= 31'd1;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        seed      <= work;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work  <= seed;
      bcnt  <= '0;
      steps <= opcode ? StepW'(1) : StepW'(WARMUP_STEPS);
    end
    if (state == ST_HASH) begin
      bcnt <= bcnt + ByteCntW'(1);
    end
    if (state == ST_SEED) begin
      // A zero hash would lock the generator at zero.
      work <= (masked == '0) ? 31'd1 : masked[30:0];
    end
    if (state == ST_WAIT && step_done) begin
      work  <= step_result;
      steps <= steps - StepW'(1);
    end
    if (state == ST_DONE && out_free) begin
      seed_out <= work;
      fraction <= dbl + {31'b0, dbl_ge};
    end
  end

  a_step_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    step_done |-> state == ST_WAIT)
    else $error("step result arrived outside the wait state");

  a_seed_in_range: assert property (@(posedge clk) disable iff (rst)
    seed != '0 && seed != LehmerMod)
    else $error("generator state left the valid range");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted word did not start the sequencer");

  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_free |=> out_valid && seed_out == $past(work))
    else $error("finished word was not loaded into the output register");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the seeded Lehmer generator: directed and random words.
module testbench;
  import hlrng_pkg::*;

  localparam logic OP_RESEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;
  // Multiplicative inverse of 1025 modulo 2^32, used to run a byte mix backwards.
  localparam logic [31:0] Inv1025 = 32'hc00ffc01;
  localparam int RandomWords = 500;
  localparam int HoldCycles = 300;
  localparam int Buckets = 65536;
  localparam int BucketDepth = 6;

  // Predicts the generator state word by word and checks output words in order.
  class lehmer_checker;
    localparam int MaxReports = 10;
    logic [30:0] seed_now;
    logic [30:0] seed_q[$];
    logic [31:0] frac_q[$];
    int n_checked;
    int n_errors;
    int n_reseeds;
    int n_draws;

    function new();
      seed_now = 31'd1;
      n_checked = 0;
      n_errors = 0;
      n_reseeds = 0;
      n_draws = 0;
    endfunction

    function logic [31:0] mix_byte(logic [31:0] h, logic [7:0] b);
      logic [31:0] t;
      t = h + {{24{b[7]}}, b};
      t = t + (t << 10);
      return t ^ (t >> 6);
    endfunction

    function logic [31:0] mix_word(logic [31:0] h, logic [63:0] w, int nbytes);
      logic [31:0] t;
      int i;
      t = h;
      for (i = 0; i < nbytes; i++) t = mix_byte(t, w[8*i +: 8]);
      return t;
    endfunction

    function logic [31:0] coord_hash(logic [31:0] idx, logic [63:0] x, logic [63:0] y,
                                     logic [63:0] z);
      logic [31:0] t;
      t = mix_word(32'd0, {32'd0, idx}, 4);
      t = mix_word(t, x, 8);
      t = mix_word(t, y, 8);
      t = mix_word(t, z, 8);
      t = t + (t << 3);
      t = t ^ (t >> 11);
      t = t + (t << 15);
      return t;
    endfunction

    function logic [30:0] lehmer_step(logic [30:0] s);
      logic [63:0] p;
      p = {33'd0, s} * {49'd0, LehmerMult};
      p = p % {33'd0, LehmerMod};
      return p[30:0];
    endfunction

    function void note_word(logic op, logic [31:0] idx, logic [63:0] x, logic [63:0] y,
                            logic [63:0] z);
      logic [31:0] h;
      logic [30:0] s;
      logic [63:0] q;
      int i;
      if (op == OP_RESEED) begin
        h = coord_hash(idx, x, y, z) & ReseedMask;
        s = (h == 32'd0) ? 31'd1 : h[30:0];
        for (i = 0; i < WarmupStepsDef; i++) s = lehmer_step(s);
        n_reseeds++;
      end else begin
        s = lehmer_step(seed_now);
        n_draws++;
      end
      seed_now = s;
      q = {1'b0, s, 32'd0} / {33'd0, LehmerMod};
      seed_q.push_back(s);
      frac_q.push_back(q[31:0]);
    endfunction

    function void check_word(logic [30:0] seed, logic [31:0] frac);
      logic [30:0] exp_seed;
      logic [31:0] exp_frac;
      if (seed_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports)
          $display("error: unexpected output word seed_out=%h fraction=%h", seed, frac);
        return;
      end
      exp_seed = seed_q.pop_front();
      exp_frac = frac_q.pop_front();
      n_checked++;
      if (seed !== exp_seed || frac !== exp_frac) begin
        n_errors++;
        if (n_errors <= MaxReports)
          $display("error: word %0d seed_out exp %h got %h, fraction exp %h got %h",
                   n_checked, exp_seed, seed, exp_frac, frac);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic opcode;
  logic signed [31:0] base_index;
  logic [63:0] coord_x;
  logic [63:0] coord_y;
  logic [63:0] coord_z;
  logic out_valid;
  logic out_stall;
  logic [30:0] seed_out;
  logic [31:0] fraction;

  lehmer_checker sb = new();
  int n_sent = 0;
  int n_results = 0;

  // Buckets of hash values that the last two bytes can bring to zero.
  logic [31:0] tail_key [0:Buckets*BucketDepth-1];
  logic [15:0] tail_val [0:Buckets*BucketDepth-1];
  int tail_cnt [0:Buckets-1];

  hash_seeded_lehmer_rng u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .base_index (base_index),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .seed_out   (seed_out),
    .fraction   (fraction)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [63:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offers one word after a random gap (none for words 200 to 259) and returns at the edge that accepts it.
  task automatic send_word(input logic op, input logic [31:0] idx, input logic [63:0] x,
                           input logic [63:0] y, input logic [63:0] z);
    int gap;
    gap = (n_sent >= 200 && n_sent < 260) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    base_index <= idx;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(op, idx, x, y, z);
    n_sent++;
  endtask

  initial begin : receiver
    int wait_cycles;
    forever begin
      // One long hold-off lets the block fill up and stall its input.
      if (n_results == 100) wait_cycles = HoldCycles;
      else if (n_results >= 300 && n_results < 360) wait_cycles = 0;
      else wait_cycles = $urandom_range(0, 5);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      sb.check_word(seed_out, fraction);
      n_results++;
    end
  end

  initial begin : stimulus
    logic [31:0] h;
    logic [31:0] t;
    logic [31:0] u;
    logic [7:0] b26;
    logic [7:0] b27;
    logic [31:0] zidx;
    logic [31:0] zlow;
    logic [63:0] zx;
    logic [63:0] zy;
    logic [63:0] zz;
    logic zero_found;
    int i;
    int j;
    int k;
    int m;
    int attempt;
    int n;

    rst <= 1'b1;
    in_valid <= 1'b0;
    opcode <= OP_DRAW;
    base_index <= '0;
    coord_x <= '0;
    coord_y <= '0;
    coord_z <= '0;

    // Find a reseed word whose hash is exactly zero by meeting in the middle:
    // run the last two byte mixes backwards from zero, then search two bytes forward.
    for (i = 0; i < Buckets; i++) tail_cnt[i] = 0;
    for (i = 0; i < 65536; i++) begin
      b26 = i[7:0];
      b27 = i[15:8];
      h = 32'd0 - {{24{b27[7]}}, b27};
      t = h ^ (h >> 6);
      t = t ^ (t >> 12);
      t = t ^ (t >> 24);
      h = t * Inv1025 - {{24{b26[7]}}, b26};
      k = {16'd0, h[15:0]};
      if (tail_cnt[k] < BucketDepth) begin
        tail_key[k*BucketDepth + tail_cnt[k]] = h;
        tail_val[k*BucketDepth + tail_cnt[k]] = i[15:0];
        tail_cnt[k]++;
      end
    end
    zero_found = 1'b0;
    attempt = 0;
    zidx = '0;
    zx = '0;
    zy = '0;
    zz = '0;
    while (!zero_found && attempt < 16) begin
      zidx = $urandom;
      zx = {$urandom, $urandom};
      zy = {$urandom, $urandom};
      zlow = $urandom;
      h = sb.mix_word(32'd0, {32'd0, zidx}, 4);
      h = sb.mix_word(h, zx, 8);
      h = sb.mix_word(h, zy, 8);
      h = sb.mix_word(h, {32'd0, zlow}, 4);
      for (i = 0; i < 256 && !zero_found; i++) begin
        t = sb.mix_byte(h, i[7:0]);
        for (j = 0; j < 256 && !zero_found; j++) begin
          u = sb.mix_byte(t, j[7:0]);
          k = {16'd0, u[15:0]};
          for (m = 0; m < tail_cnt[k]; m++)
            if (tail_key[k*BucketDepth + m] == u) begin
              zero_found = 1'b1;
              zz = {tail_val[k*BucketDepth + m], j[7:0], i[7:0], zlow};
            end
        end
      end
      attempt++;
    end
    if (zero_found && (sb.coord_hash(zidx, zx, zy, zz) & ReseedMask) != 32'd0)
      zero_found = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Draws straight from the reset state, then reseeds at the field extremes.
    send_word(OP_DRAW, 32'd0, 64'd0, 64'd0, 64'd0);
    send_word(OP_DRAW, 32'hffffffff, '1, '1, '1);
    send_word(OP_RESEED, 32'd0, 64'd0, 64'd0, 64'd0);
    send_word(OP_RESEED, 32'h7fffffff, '1, '1, '1);
    send_word(OP_RESEED, 32'h80000000, {8{8'h80}}, {8{8'h80}}, {8{8'h80}});
    send_word(OP_RESEED, 32'hffffffff, {8{8'h7f}}, {8{8'h7f}}, {8{8'h7f}});
    send_word(OP_DRAW, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom});
    send_word(OP_RESEED, 32'h55555555, {16{4'h5}}, {16{4'ha}}, {16{4'h5}});
    send_word(OP_RESEED, 32'haaaaaaaa, {16{4'ha}}, {16{4'h5}}, {16{4'ha}});
    send_word(OP_DRAW, 32'h80000000, '0, '1, '0);
    // Special floating-point coordinates: 1.0, -0.0 and +infinity.
    send_word(OP_RESEED, 32'd1, 64'h3ff0000000000000, 64'h8000000000000000,
              64'h7ff0000000000000);
    if (zero_found) begin
      send_word(OP_RESEED, zidx, zx, zy, zz);
      send_word(OP_DRAW, 32'd0, 64'd0, 64'd0, 64'd0);
    end
    for (i = 0; i < 4; i++) send_word(OP_DRAW, $urandom, '0, '0, '0);
    send_word(OP_RESEED, 32'h0000007f, 64'h00000000000000ff, 64'hff00000000000000,
              64'h8000000000000001);

    for (n = 0; n < RandomWords; n++) begin
      if ($urandom_range(0, 9) < 3)
        send_word(OP_RESEED, $urandom, rand_coord(), rand_coord(), rand_coord());
      else
        send_word(OP_DRAW, $urandom, rand_coord(), rand_coord(), rand_coord());
    end
    in_valid <= 1'b0;

    while (sb.seed_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("summary: %0d words in (%0d reseeds, %0d draws), %0d output words checked",
             n_sent, sb.n_reseeds, sb.n_draws, sb.n_checked);
    $display("summary: zero-hash reseed %s, one output hold-off of %0d cycles, %0d errors",
             zero_found ? "covered" : "not reached", HoldCycles, sb.n_errors);
    if (sb.n_errors == 0 && sb.seed_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
